### rtl/core/dpcd_pkg.sv
// ----------------------------------------------------------------------------
// dpcd_pkg
// Shared types, constants and the segment decoder for the press counter.
// ----------------------------------------------------------------------------
package dpcd_pkg;

  localparam int unsigned CountW      = 7;
  localparam int unsigned DigitW      = 4;
  localparam int unsigned SegW        = 7;
  localparam int unsigned RunW        = 8;

  localparam logic [CountW-1:0] CountMax      = 7'd99;
  localparam logic [DigitW-1:0] DigitMax      = 4'd9;
  localparam logic [RunW-1:0]   RunMax        = 8'hFF;
  localparam logic [RunW-1:0]   DebounceReset = 8'd5;

  // tick kinds
  localparam logic CmdSample = 1'b0;
  localparam logic CmdMux    = 1'b1;

  typedef struct packed {
    logic [SegW-1:0]   segments;
    logic              right_enable;
    logic              left_enable;
    logic [CountW-1:0] press_count;
  } res_t;

  // active-high segment patterns, bit 0 = segment A
  function automatic logic [SegW-1:0] seg_decode(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] seg;
    case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      default: seg = 7'h6F;
    endcase
    return seg;
  endfunction

endpackage

### rtl/core/debounced_press_counter_display.sv
// ----------------------------------------------------------------------------
// debounced_press_counter_display
// Switch debouncer, 0..99 press counter and two-digit display multiplexer.
// ----------------------------------------------------------------------------
// channel | direction | handshake               | payload
// cfg     | in        | cfg_we_i                | cfg_wdata_i (debounce threshold)
// in      | in        | in_valid_i / in_stall_o | command_i, switch_level_i
// out     | out       | out_valid_o/out_stall_i | segments_o, right_enable_o,
//         |           |                         | left_enable_o, press_count_o
//
// One tick per clock unless the input is stalled; its result is registered.
// The state update and segment decode sit between the tick and the result
// register. A skid register holds one extra result while the output is
// stalled, so the input stalls only once both are full.
// Reset clears the counter, debouncer and digit select, threshold back to 5.
// ----------------------------------------------------------------------------
module debounced_press_counter_display
  import dpcd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RunW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  logic              switch_level_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SegW-1:0]   segments_o,
  output logic              right_enable_o,
  output logic              left_enable_o,
  output logic [CountW-1:0] press_count_o
);

  logic [RunW-1:0]   thr_q;
  logic [CountW-1:0] count_q, count_d;
  logic [DigitW-1:0] ones_q, ones_d, tens_q, tens_d;
  logic              right_q, right_d;
  logic              deb_q, deb_d;
  logic [RunW-1:0]   run_q, run_d;
  logic [RunW-1:0]   run_inc;
  logic              pressed_now;
  logic [DigitW-1:0] digit;
  res_t              res;

  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;
  logic              skid_valid_q, skid_valid_d;
  res_t              skid_q, skid_d;

  logic              in_accept;
  logic              out_free;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i & ~skid_valid_q;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // tick processing
  always_comb begin
    count_d     = count_q;
    ones_d      = ones_q;
    tens_d      = tens_q;
    right_d     = right_q;
    deb_d       = deb_q;
    run_d       = run_q;
    pressed_now = ~switch_level_i;
    run_inc     = (run_q == RunMax) ? run_q : run_q + 8'd1;
    if (in_accept) begin
      if (command_i == CmdMux) begin
        right_d = ~right_q;
      end else if (pressed_now != deb_q) begin
        run_d = run_inc;
        // a zero threshold behaves as one
        if (run_inc >= thr_q) begin
          deb_d = pressed_now;
          if (pressed_now) begin
            if (count_q >= CountMax) begin
              count_d = '0;
              ones_d  = '0;
              tens_d  = '0;
            end else begin
              count_d = count_q + 7'd1;
              if (ones_q == DigitMax) begin
                ones_d = '0;
                tens_d = tens_q + 4'd1;
              end else begin
                ones_d = ones_q + 4'd1;
              end
            end
          end
        end
      end else begin
        run_d = '0;
      end
    end
  end

  always_comb begin
    digit            = right_d ? ones_d : tens_d;
    res.segments     = seg_decode(digit);
    res.right_enable = right_d;
    res.left_enable  = ~right_d;
    res.press_count  = count_d;
  end

  // output register with skid stage
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_accept;
        if (in_accept) begin
          out_d = res;
        end
      end
    end else if (in_accept) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= DebounceReset;
      count_q      <= '0;
      ones_q       <= '0;
      tens_q       <= '0;
      right_q      <= 1'b0;
      deb_q        <= 1'b0;
      run_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      count_q      <= count_d;
      ones_q       <= ones_d;
      tens_q       <= tens_d;
      right_q      <= right_d;
      deb_q        <= deb_d;
      run_q        <= run_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign segments_o     = out_q.segments;
  assign right_enable_o = out_q.right_enable;
  assign left_enable_o  = out_q.left_enable;
  assign press_count_o  = out_q.press_count;

endmodule

### rtl/core/dpcd_checker.sv
// ----------------------------------------------------------------------------
// dpcd_checker
// Port-level checks for the press counter display, bound to the top level.
// ----------------------------------------------------------------------------
module dpcd_checker
  import dpcd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [SegW-1:0]   segments_o,
  input logic              right_enable_o,
  input logic              left_enable_o,
  input logic [CountW-1:0] press_count_o
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(segments_o)
      && $stable(press_count_o) && $stable(right_enable_o))
    else $error("stalled result changed");

  // exactly one digit lit
  a_one_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> right_enable_o != left_enable_o)
    else $error("digit enables not exclusive");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> press_count_o <= CountMax)
    else $error("press count out of range");

  // a result only appears after an accepted tick
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result without input transaction");

  // input stalls only after the output was backed up
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

endmodule

bind debounced_press_counter_display dpcd_checker u_dpcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .segments_o    (segments_o),
  .right_enable_o(right_enable_o),
  .left_enable_o (left_enable_o),
  .press_count_o (press_count_o)
);

### tb/sv/tb_dpcd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dpcd_checker
// Watches the tick, config and display channels of the press counter. Tracks
// its own debouncer, counter and digit select, and checks every display
// transaction against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_dpcd_checker
  import dpcd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RunW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_o,
  input  logic              command_i,
  input  logic              switch_level_i,
  input  logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic [SegW-1:0]   segments_o,
  input  logic              right_enable_o,
  input  logic              left_enable_o,
  input  logic [CountW-1:0] press_count_o,
  output int                fail_count_o,
  output int                pending_o
);

  localparam logic [SegW-1:0] DigitSegs [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  logic [CountW-1:0] press_total;
  logic              right_lit;
  logic              held_pressed;
  logic [RunW-1:0]   differ_run;
  logic [RunW-1:0]   threshold;
  res_t              display_q [$];
  int                fails;

  // Applies one tick to the tracked state and returns the display it shows.
  function automatic res_t next_display(input logic cmd, input logic level);
    res_t              shown;
    logic              pressed_now;
    logic [DigitW-1:0] digit;
    pressed_now = ~level;
    if (cmd == CmdMux) begin
      right_lit = ~right_lit;
    end else if (pressed_now != held_pressed) begin
      if (differ_run != RunMax) differ_run = differ_run + 1'b1;
      // a zero threshold behaves like one: the run is at least 1 here
      if (differ_run >= threshold) begin
        held_pressed = pressed_now;
        if (pressed_now) begin
          press_total = (press_total >= CountMax) ? '0 : press_total + 1'b1;
        end
      end
    end else begin
      differ_run = '0;
    end
    digit = right_lit ? DigitW'(press_total % 7'd10) : DigitW'(press_total / 7'd10);
    shown.segments     = DigitSegs[digit];
    shown.right_enable = right_lit;
    shown.left_enable  = ~right_lit;
    shown.press_count  = press_total;
    return shown;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      press_total  = '0;
      right_lit    = 1'b0;
      held_pressed = 1'b0;
      differ_run   = '0;
      threshold    = DebounceReset;
      display_q.delete();
      fails = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (display_q.size() == 0) begin
          $display("%0t: display transaction with none expected, expected none, %s",
                   $time, "actual");
          $display("%0t:   actual %h/%b/%b/%0d",
                   $time, segments_o, right_enable_o, left_enable_o, press_count_o);
          fails++;
        end else begin
          want = display_q.pop_front();
          check_field("segments", int'(want.segments), int'(segments_o));
          check_field("right_enable", int'(want.right_enable), int'(right_enable_o));
          check_field("left_enable", int'(want.left_enable), int'(left_enable_o));
          check_field("press_count", int'(want.press_count), int'(press_count_o));
        end
      end
      if (cfg_we_i) threshold = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        display_q.push_back(next_display(command_i, switch_level_i));
      end
    end
    fail_count_o <= fails;
    pending_o    <= display_q.size();
  end

endmodule

### tb/sv/tb_debounced_press_counter_display.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_debounced_press_counter_display
// Drives switch and multiplex ticks into the press counter: a directed run
// over the threshold extremes and the count wrap, then random press and
// release sequences with bounce and noise under several thresholds. Sender
// gaps and receiver stalls are random; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb_debounced_press_counter_display;
  import dpcd_pkg::*;

  localparam int   TargetTicks   = 1050;
  localparam int   IdleLimit     = 2000;
  localparam logic LevelPressed  = 1'b0;
  localparam logic LevelReleased = 1'b1;

  typedef enum int {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              cfg_we       = 1'b0;
  logic [RunW-1:0]   cfg_wdata    = '0;
  logic              in_valid     = 1'b0;
  logic              command      = CmdSample;
  logic              switch_level = LevelReleased;
  logic              out_stall    = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [SegW-1:0]   segments;
  logic              right_en;
  logic              left_en;
  logic [CountW-1:0] press_count;
  int                fail_count;
  int                pending;

  int          ticks_sent  = 0;
  int          burst_left  = 0;
  int          idle_cycles = 0;
  int          mode_left   = 0;
  int          cyc         = 0;
  stall_mode_e stall_mode  = StallNone;
  int          threshold   = int'(DebounceReset);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  debounced_press_counter_display i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .switch_level_i (switch_level),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .segments_o     (segments),
    .right_enable_o (right_en),
    .left_enable_o  (left_en),
    .press_count_o  (press_count)
  );

  tb_dpcd_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .switch_level_i (switch_level),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .segments_o     (segments),
    .right_enable_o (right_en),
    .left_enable_o  (left_en),
    .press_count_o  (press_count),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // One tick transaction; the sender may idle between bursts of random length.
  task automatic send_tick(input logic cmd, input logic level);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    switch_level <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    ticks_sent++;
  endtask

  // Switch sample, sometimes preceded by a multiplex tick.
  task automatic sample(input logic level);
    if ($urandom_range(0, 4) == 0) send_tick(CmdMux, 1'($urandom_range(0, 1)));
    send_tick(CmdSample, level);
  endtask

  task automatic hold_level(input logic level, input int n);
    repeat (n) sample(level);
  endtask

  // Settle on a level, with sub-threshold bounce first when the threshold allows.
  task automatic bounce_to(input logic level);
    if (threshold > 1) begin
      repeat ($urandom_range(0, 3)) begin
        hold_level(level, $urandom_range(1, threshold - 1));
        sample(~level);
      end
    end
    hold_level(level, threshold + $urandom_range(0, 2));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input int value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value[RunW-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    threshold = value;
  endtask

  // Receiver stall pattern, switching mode every so often.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    cyc++;
    case (stall_mode)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
      default:    out_stall <= cyc[2];
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("debounced_press_counter_display test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int value;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset threshold: digit toggling, a run one short, then press and release
    send_tick(CmdMux, LevelReleased);
    send_tick(CmdMux, LevelPressed);
    repeat (4) send_tick(CmdSample, LevelPressed);
    send_tick(CmdSample, LevelReleased);
    repeat (5) send_tick(CmdSample, LevelPressed);
    send_tick(CmdMux, LevelPressed);
    repeat (5) send_tick(CmdSample, LevelReleased);
    send_tick(CmdMux, LevelReleased);

    // zero threshold acts like one
    write_threshold(0);
    repeat (3) begin
      send_tick(CmdSample, LevelPressed);
      send_tick(CmdSample, LevelReleased);
    end

    // max threshold; the run stays pressed past it, release under threshold 1
    write_threshold(int'(RunMax));
    repeat (258) send_tick(CmdSample, LevelPressed);
    write_threshold(1);
    send_tick(CmdSample, LevelReleased);

    // enough presses to carry the count through 99 -> 0
    repeat (100) begin
      send_tick(CmdSample, LevelPressed);
      if ($urandom_range(0, 3) == 0) send_tick(CmdMux, 1'($urandom_range(0, 1)));
      send_tick(CmdSample, LevelReleased);
    end

    while (ticks_sent < TargetTicks) begin
      case ($urandom_range(0, 3))
        0:       value = 1;
        1:       value = $urandom_range(2, 4);
        2:       value = $urandom_range(5, 8);
        default: value = int'(DebounceReset);
      endcase
      write_threshold(value);
      repeat ($urandom_range(4, 12)) begin
        if (ticks_sent >= TargetTicks) break;
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 6)) begin
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end else begin
          bounce_to(LevelPressed);
          bounce_to(LevelReleased);
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("debounced_press_counter_display test passed");
    end else begin
      $display("debounced_press_counter_display test failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/dpcd_pkg.sv
rtl/core/debounced_press_counter_display.sv
rtl/core/dpcd_checker.sv
tb/sv/tb_dpcd_checker.sv
tb/sv/tb_debounced_press_counter_display.sv
